[design/assert_macros.svh]
// Assertion macros shared by the spatial word histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SWH_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define SWH_ASSERT(label, clk, rst, prop)
`define SWH_NEVER(label, clk, rst, cond)
`endif
`endif

[design/swh_pkg.sv]
// Types, widths and codes shared by the spatial word histogram unit.
package swh_pkg;

   localparam int OPCODE_W     = 2;
   localparam int POS_W        = 17;
   localparam int WORD_W       = 10;
   localparam int WEIGHT_W     = 24;
   localparam int BIN_W        = 14;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 24;
   localparam int GRID_RES_W   = 3;
   localparam int VOCAB_SIZE_W = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;

   localparam int DEF_MAX_VOCAB = 1024;
   localparam int DEF_MAX_RES   = 4;

   localparam logic [GRID_RES_W-1:0]   GRID_RES_RESET   = GRID_RES_W'(1);
   localparam logic [VOCAB_SIZE_W-1:0] VOCAB_SIZE_RESET = VOCAB_SIZE_W'(1024);
   localparam logic [COUNT_W-1:0]      COUNT_MAX        = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_RES   = 2'd0,
      CSR_VOCAB_SIZE = 2'd1,
      CSR_NORMALIZE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_CELL,
      ST_ADDR,
      ST_READ,
      ST_MODIFY,
      ST_DIVIDE,
      ST_CLEAR
   } state_type;

endpackage

[design/swh_div.sv]
// Bit-serial restoring divider for normalized bin reads.
module swh_div
   import swh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [VALUE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(VALUE_W);

   logic               active_ff;
   logic               done_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] rem_in;
   logic [VALUE_W-1:0] quo_ff;
   logic [VALUE_W-1:0] quo_in;
   logic [COUNT_W-1:0] div_ff;
   logic [COUNT_W:0]   trial;
   logic               take;

   // one quotient bit per cycle, MSB first
   always_comb begin
      trial  = {rem_ff, quo_ff[VALUE_W-1]};
      take   = trial >= {1'b0, div_ff};
      rem_in = take ? COUNT_W'(trial - {1'b0, div_ff}) : trial[COUNT_W-1:0];
      quo_in = {quo_ff[VALUE_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= !start && active_ff && (step_ff == STEP_W'(VALUE_W - 1));
         if (start) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
         end else if (active_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (active_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/spatial_word_histogram_unit.sv]
// Top level: spatial grid of word histograms held in one on-chip memory.
//
//  channel   ports                      transfer when
//  --------  -------------------------  ------------------------------
//  request   req_start, busy, req_*     req_start && !busy
//  response  rsp_strobe, rsp_*          rsp_strobe (one cycle, no stall)
//  config    csr_valid, csr_ready, csr_*  csr_valid && csr_ready
//
//  Accumulate and plain read: coordinate, cell, address, memory read and
//  modify/write in turn; the next item is taken in the write cycle.
//  Normalized read: the steps above, then the serial divider with busy high;
//  the next transfer is taken once the unit is back in idle.
//  Clear, and the pass after reset: one memory entry per cycle,
//  over all MAX_RES*MAX_RES*MAX_VOCAB entries (16384 at the defaults) with busy high,
//  then back to idle before the next transfer.
//  Responses are single-cycle strobes; the receiver cannot stall them.
`include "assert_macros.svh"

module spatial_word_histogram_unit
   import swh_pkg::*;
#(
   parameter int MAX_VOCAB = DEF_MAX_VOCAB,
   parameter int MAX_RES   = DEF_MAX_RES
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   output logic                    busy,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   input  logic [WORD_W-1:0]       req_word_index,
   input  logic [WEIGHT_W-1:0]     req_weight,
   input  logic                    req_last_of_feature,
   input  logic [BIN_W-1:0]        req_bin_index,
   output logic                    rsp_strobe,
   output logic [VALUE_W-1:0]      rsp_bin_value,
   output logic                    rsp_out_of_range,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RES_W   = $clog2(MAX_RES + 1);
   localparam int VOC_W   = $clog2(MAX_VOCAB + 1);
   localparam int CELLS   = MAX_RES * MAX_RES;
   localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COORD_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int DEPTH   = CELLS * MAX_VOCAB;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W  = CELL_W + VOC_W;
   localparam int SUM_W   = ((PROD_W > WORD_W) ? PROD_W : WORD_W) + 1;
   localparam int LIM_W   = 2 * RES_W + VOC_W;
   localparam int CMP_W   = ((LIM_W > BIN_W) ? LIM_W : BIN_W) + 1;
   localparam int XP_W    = POS_W + RES_W;
   localparam int CP_W    = COORD_W + RES_W + 1;

   // configuration
   logic [GRID_RES_W-1:0]   grid_res_ff;
   logic [VOCAB_SIZE_W-1:0] vocab_size_ff;
   logic                    normalize_ff;
   logic [RES_W-1:0]        eff_res;
   logic [VOC_W-1:0]        eff_voc;
   logic [2*RES_W-1:0]      res_sq_ff;
   logic [LIM_W-1:0]        limit_ff;

   // control
   state_type            state_ff;
   state_type            state_in;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [ADDR_W-1:0]    clr_addr_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic                 accept;
   logic                 will_divide;
   logic                 div_start;
   logic                 div_done;
   logic [VALUE_W-1:0]   div_quotient;
   logic                 rsp_state_ok;

   // latched item and pipeline values
   logic                 op_read_ff;
   logic [POS_W-1:0]     pos_x_ff;
   logic [POS_W-1:0]     pos_y_ff;
   logic [WORD_W-1:0]    word_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [BIN_W-1:0]     bin_ff;
   logic [COORD_W-1:0]   cx_ff;
   logic [COORD_W-1:0]   cy_ff;
   logic [CELL_W-1:0]    cell_ff;
   logic [SUM_W-1:0]     addr_sum_ff;
   logic                 acc_ok_ff;
   logic                 range_bad_ff;
   logic                 wr_ok_ff;

   logic [XP_W-1:0]      prod_x;
   logic [XP_W-1:0]      prod_y;
   logic [RES_W:0]       cx_raw;
   logic [RES_W:0]       cy_raw;
   logic [RES_W:0]       res_top;
   logic [CP_W-1:0]      cell_full;

   // memory
   logic [VALUE_W-1:0]   hist_mem [DEPTH];
   logic [VALUE_W-1:0]   rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [VALUE_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [VALUE_W:0]     sat_sum;

   // response
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [VALUE_W-1:0]   rsp_value_in;
   logic                 rsp_oor_ff;
   logic                 rsp_oor_in;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_res_ff   <= GRID_RES_RESET;
         vocab_size_ff <= VOCAB_SIZE_RESET;
         normalize_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_RES:   grid_res_ff   <= csr_wdata[GRID_RES_W-1:0];
            CSR_VOCAB_SIZE: vocab_size_ff <= csr_wdata[VOCAB_SIZE_W-1:0];
            CSR_NORMALIZE:  normalize_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // out-of-range register values clamp into the supported range
   always_comb begin
      if (grid_res_ff == '0) begin
         eff_res = RES_W'(1);
      end else if (32'(grid_res_ff) > MAX_RES) begin
         eff_res = RES_W'(MAX_RES);
      end else begin
         eff_res = RES_W'(grid_res_ff);
      end
      if (vocab_size_ff == '0) begin
         eff_voc = VOC_W'(1);
      end else if (32'(vocab_size_ff) > MAX_VOCAB) begin
         eff_voc = VOC_W'(MAX_VOCAB);
      end else begin
         eff_voc = VOC_W'(vocab_size_ff);
      end
   end

   // read limit is registered through res_sq_ff and limit_ff and settles before any read needs it
   always_ff @(posedge clock) begin
      res_sq_ff <= (2*RES_W)'(eff_res) * (2*RES_W)'(eff_res);
      limit_ff  <= LIM_W'(res_sq_ff) * LIM_W'(eff_voc);
   end

   // ---------------- control ----------------
   assign accept      = req_start && !busy;
   assign will_divide = op_read_ff && !range_bad_ff && normalize_ff && (count_ff != '0);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      busy         = 1'b1;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_COORD:  state_in = ST_CELL;
         ST_CELL:   state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ:   state_in = ST_MODIFY;
         ST_MODIFY: begin
            busy     = will_divide;
            state_in = will_divide ? ST_DIVIDE : ST_IDLE;
            if (op_read_ff) begin
               if (range_bad_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_oor_in   = 1'b1;
               end else if (will_divide) begin
                  div_start = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = rd_data_ff;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = div_quotient;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (accept) begin
         case (req_opcode) inside
            OP_ACCUM, OP_READ: state_in = ST_COORD;
            OP_CLEAR: begin
               state_in    = ST_CLEAR;
               clr_addr_in = '0;
            end
            default: ;
         endcase
      end
   end

   // feature count moves at the transfer itself
   always_comb begin
      count_in = count_ff;
      if (accept && req_opcode == OP_CLEAR) begin
         count_in = '0;
      end else if (accept && req_opcode == OP_ACCUM && req_last_of_feature
                   && count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_value_ff <= rsp_value_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   // ---------------- address pipeline ----------------
   always_comb begin
      prod_x    = XP_W'(pos_x_ff) * XP_W'(eff_res);
      prod_y    = XP_W'(pos_y_ff) * XP_W'(eff_res);
      cx_raw    = prod_x[XP_W-1:16];
      cy_raw    = prod_y[XP_W-1:16];
      res_top   = (RES_W+1)'(eff_res) - (RES_W+1)'(1);
      if (cx_raw > res_top) cx_raw = res_top;
      if (cy_raw > res_top) cy_raw = res_top;
      cell_full = CP_W'(cy_ff) * CP_W'(eff_res) + CP_W'(cx_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_read_ff <= (req_opcode == OP_READ);
         pos_x_ff   <= req_pos_x;
         pos_y_ff   <= req_pos_y;
         word_ff    <= req_word_index;
         weight_ff  <= req_weight;
         bin_ff     <= req_bin_index;
      end
      if (state_ff == ST_COORD) begin
         cx_ff <= COORD_W'(cx_raw);
         cy_ff <= COORD_W'(cy_raw);
      end
      if (state_ff == ST_CELL) begin
         cell_ff <= CELL_W'(cell_full);
      end
      if (state_ff == ST_ADDR) begin
         addr_sum_ff  <= SUM_W'(cell_ff) * SUM_W'(eff_voc) + SUM_W'(word_ff);
         acc_ok_ff    <= SUM_W'(word_ff) < SUM_W'(eff_voc);
         range_bad_ff <= (CMP_W'(bin_ff) >= CMP_W'(limit_ff))
                         || (CMP_W'(bin_ff) >= CMP_W'(DEPTH));
      end
      if (state_ff == ST_READ) begin
         wr_ok_ff <= acc_ok_ff && (addr_sum_ff < SUM_W'(DEPTH));
      end
   end

   // ---------------- histogram memory ----------------
   // a new item is taken no earlier than the write-back cycle, so the read and the write-back of an
   // entry never overlap with another item's access
   always_comb begin
      sat_sum   = {1'b0, rd_data_ff} + (VALUE_W+1)'(weight_ff);
      mem_raddr = op_read_ff ? ADDR_W'(bin_ff) : addr_sum_ff[ADDR_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = addr_sum_ff[ADDR_W-1:0];
      mem_wdata = sat_sum[VALUE_W] ? '1 : sat_sum[VALUE_W-1:0];
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_MODIFY && !op_read_ff && wr_ok_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[mem_raddr];
   end

   // ---------------- normalizing divider ----------------
   swh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_bin_value    = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   assign rsp_state_ok = (state_ff == ST_MODIFY) || (state_ff == ST_DIVIDE);

   `SWH_ASSERT(a_rsp_source, clock, reset, rsp_valid_ff |-> $past(rsp_state_ok))
   `SWH_ASSERT(a_clear_busy, clock, reset, state_ff == ST_CLEAR |-> busy)
   `SWH_ASSERT(a_div_done_state, clock, reset, div_done |-> state_ff == ST_DIVIDE)
   `SWH_ASSERT(a_accept_state, clock, reset, accept |-> state_ff == ST_IDLE || state_ff == ST_MODIFY)
   `SWH_NEVER(a_oor_zero, clock, reset, rsp_valid_ff && rsp_oor_ff && rsp_value_ff != '0)

endmodule

[sim/tb_spatial_word_histogram_unit.sv]
// Self-checking testbench for the spatial word histogram unit.
module tb_spatial_word_histogram_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import swh_pkg::*;

   localparam int HIST_DEPTH = DEF_MAX_RES * DEF_MAX_RES * DEF_MAX_VOCAB;
   localparam logic [OPCODE_W-1:0]    OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   // settle margin; the longest item other than a clear is a normalized read
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [WORD_W-1:0]   word;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic [BIN_W-1:0]    bin;
   } hist_op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               oor;
   } bin_reading_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_start = 1'b0;
   logic                   busy;
   logic [OPCODE_W-1:0]    req_opcode = '0;
   logic [POS_W-1:0]       req_pos_x = '0;
   logic [POS_W-1:0]       req_pos_y = '0;
   logic [WORD_W-1:0]      req_word_index = '0;
   logic [WEIGHT_W-1:0]    req_weight = '0;
   logic                   req_last_of_feature = 1'b0;
   logic [BIN_W-1:0]       req_bin_index = '0;
   logic                   rsp_strobe;
   logic [VALUE_W-1:0]     rsp_bin_value;
   logic                   rsp_out_of_range;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow copy of the block's state and registers
   logic [VALUE_W-1:0]      hist_model [HIST_DEPTH] = '{default: '0};
   logic [COUNT_W-1:0]      feat_count = '0;
   logic [GRID_RES_W-1:0]   grid_res_reg = GRID_RES_RESET;
   logic [VOCAB_SIZE_W-1:0] vocab_reg = VOCAB_SIZE_RESET;
   logic                    norm_reg = 1'b0;

   bin_reading_type pending_reads[$];
   int unsigned     touched_bins[$];
   int              n_errors = 0;
   int              idle_pct = 23;
   int              clears_left = 3;

   spatial_word_histogram_unit #(
      .MAX_VOCAB(DEF_MAX_VOCAB),
      .MAX_RES  (DEF_MAX_RES)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_start          (req_start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_word_index     (req_word_index),
      .req_weight         (req_weight),
      .req_last_of_feature(req_last_of_feature),
      .req_bin_index      (req_bin_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_bin_value      (rsp_bin_value),
      .rsp_out_of_range   (rsp_out_of_range),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned res_eff();
      if (grid_res_reg == 0) return 1;
      if (grid_res_reg > DEF_MAX_RES) return DEF_MAX_RES;
      return 32'(grid_res_reg);
   endfunction

   function automatic int unsigned vocab_eff();
      if (vocab_reg == 0) return 1;
      if (vocab_reg > DEF_MAX_VOCAB) return DEF_MAX_VOCAB;
      return 32'(vocab_reg);
   endfunction

   function automatic int unsigned cell_of(logic [POS_W-1:0] pos, int unsigned res);
      int unsigned c;
      c = (32'(pos) * res) >> 16;
      if (c >= res) c = res - 1;
      return c;
   endfunction

   function automatic int unsigned bins_in_use();
      int unsigned lim;
      lim = res_eff() * res_eff() * vocab_eff();
      return (lim > HIST_DEPTH) ? HIST_DEPTH : lim;
   endfunction

   // applies one accepted item to the shadow state, queues the read result
   function automatic void update_hist_model(hist_op_type op);
      int unsigned     res;
      int unsigned     voc;
      int unsigned     addr;
      logic [63:0]     sum;
      bin_reading_type rd;
      res = res_eff();
      voc = vocab_eff();
      case (op.opcode)
         OP_ACCUM: begin
            if (op.word < voc) begin
               addr = 0;
               if (res > 1)
                  addr = cell_of(op.pos_y, res) * res + cell_of(op.pos_x, res);
               addr = addr * voc + op.word;
               if (addr < HIST_DEPTH) begin
                  sum = 64'(hist_model[addr]) + 64'(op.weight);
                  hist_model[addr] = (sum > 64'hFFFF_FFFF) ? '1 : sum[VALUE_W-1:0];
                  touched_bins.push_back(addr);
                  if (touched_bins.size() > 64) void'(touched_bins.pop_front());
               end
            end
            if (op.last && feat_count != COUNT_MAX) feat_count = feat_count + 1'b1;
         end
         OP_READ: begin
            if (op.bin >= res * res * voc || op.bin >= HIST_DEPTH) begin
               rd.value = '0;
               rd.oor   = 1'b1;
            end else begin
               rd.value = hist_model[op.bin];
               if (norm_reg && feat_count != 0)
                  rd.value = rd.value / {8'd0, feat_count};
               rd.oor = 1'b0;
            end
            pending_reads.push_back(rd);
         end
         OP_CLEAR: begin
            foreach (hist_model[i]) hist_model[i] = '0;
            feat_count = '0;
            touched_bins.delete();
         end
         default: ;
      endcase
   endfunction

   function automatic hist_op_type random_fields();
      hist_op_type op;
      op.opcode = OPCODE_W'($urandom());
      op.pos_x  = POS_W'($urandom());
      op.pos_y  = POS_W'($urandom());
      op.word   = WORD_W'($urandom());
      op.weight = WEIGHT_W'($urandom());
      op.last   = 1'($urandom());
      op.bin    = BIN_W'($urandom());
      return op;
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 20) return POS_W'(65536);
      if (pick < 25) return '1;
      if (pick < 30) return POS_W'(65535);
      if (pick < 40) return POS_W'($urandom());
      return POS_W'($urandom_range(65536));
   endfunction

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '1;
      if (pick < 15) return '0;
      return WEIGHT_W'($urandom());
   endfunction

   function automatic int unsigned pick_read_bin();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50 && touched_bins.size() > 0)
         return touched_bins[$urandom_range(touched_bins.size() - 1)];
      if (pick < 82) return $urandom_range(bins_in_use() - 1);
      return $urandom_range(HIST_DEPTH - 1);
   endfunction

   // all stimulus tasks are entered right after a rising edge
   task automatic send_item(hist_op_type op);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
      req_start           <= 1'b1;
      req_opcode          <= op.opcode;
      req_pos_x           <= op.pos_x;
      req_pos_y           <= op.pos_y;
      req_word_index      <= op.word;
      req_weight          <= op.weight;
      req_last_of_feature <= op.last;
      req_bin_index       <= op.bin;
      do @(posedge clock); while (busy);
      update_hist_model(op);
   endtask

   task automatic send_accum(int unsigned x, int unsigned y, int unsigned word,
                             int unsigned weight, bit last);
      hist_op_type op;
      op        = random_fields();
      op.opcode = OP_ACCUM;
      op.pos_x  = POS_W'(x);
      op.pos_y  = POS_W'(y);
      op.word   = WORD_W'(word);
      op.weight = WEIGHT_W'(weight);
      op.last   = last;
      send_item(op);
   endtask

   task automatic send_read(int unsigned bin);
      hist_op_type op;
      op        = random_fields();
      op.opcode = OP_READ;
      op.bin    = BIN_W'(bin);
      send_item(op);
   endtask

   task automatic send_op(logic [OPCODE_W-1:0] code);
      hist_op_type op;
      op        = random_fields();
      op.opcode = code;
      send_item(op);
   endtask

   // register writes only once the block has drained
   task automatic set_regs(int unsigned g, int unsigned v, bit n, bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  dat [4];
      int                     cnt;
      req_start <= 1'b0;
      while (pending_reads.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      idx[0] = CSR_GRID_RES;   dat[0] = {8'($urandom()), 3'(g)};
      idx[1] = CSR_VOCAB_SIZE; dat[1] = CSR_DATA_W'(v);
      idx[2] = CSR_NORMALIZE;  dat[2] = {10'($urandom()), n};
      idx[3] = CSR_UNUSED;     dat[3] = CSR_DATA_W'($urandom());
      cnt = poke_unused ? 4 : 3;
      for (int i = 0; i < cnt; i++) begin
         csr_index <= idx[i];
         csr_wdata <= dat[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_GRID_RES:   grid_res_reg = dat[i][GRID_RES_W-1:0];
            CSR_VOCAB_SIZE: vocab_reg = dat[i][VOCAB_SIZE_W-1:0];
            CSR_NORMALIZE:  norm_reg = dat[i][0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_config();
      send_accum(0, 0, 0, 24'hFFFFFF, 1'b1);
      send_accum(17'h1FFFF, 65536, 1023, 0, 1'b0);
      send_accum(65535, 12345, 1023, 24'hABCDEF, 1'b1);
      send_read(0);
      send_read(1023);
      send_read(1024);
      send_read(16383);
      send_op(OP_UNUSED);
      send_read(0);
   endtask

   task automatic test_full_grid();
      set_regs(4, 1024, 1'b1, 1'b1);
      send_accum(65536, 65536, 1023, 24'hFFFFFF, 1'b1);   // clamps to last cell
      send_accum(17'h1FFFF, 0, 5, 24'h800000, 1'b0);
      send_accum(0, 17'h1FFFF, 5, 24'h000001, 1'b1);
      send_accum(16384, 49152, 7, 24'h123456, 1'b1);
      send_read(16383);
      send_read(3 * 1024 + 5);
      send_read(12 * 1024 + 5);
      send_read(13 * 1024 + 7);
      set_regs(4, 1024, 1'b0, 1'b0);
      send_read(16383);
      send_op(OP_CLEAR);
      clears_left--;
      send_read(16383);
   endtask

   task automatic test_reg_bounds();
      // zero register values act as one
      set_regs(0, 0, 1'b1, 1'b0);
      send_accum(65536, 65536, 0, 24'h00F000, 1'b0);
      send_accum(0, 0, 1, 24'hFFFFFF, 1'b1);   // beyond vocabulary, still counts
      send_read(0);
      send_read(1);
      // oversized values clamp to the maxima
      set_regs(7, 2047, 1'b0, 1'b1);
      send_accum(65536, 0, 1023, 24'h000100, 1'b1);
      send_read(3 * 1024 + 1023);
      send_read(16383);
   endtask

   task automatic test_saturation();
      set_regs(1, 1, 1'b0, 1'b0);
      send_op(OP_CLEAR);
      clears_left--;
      for (int i = 0; i < 280; i++) begin
         if (i % 16 == 15)
            send_read($urandom_range(1));
         else if ($urandom_range(9) == 0)
            send_accum(rand_pos(), rand_pos(), $urandom_range(1, 1023), '1, 1'($urandom()));
         else
            send_accum(rand_pos(), rand_pos(), 0, $urandom_range(24'hF00000, 24'hFFFFFF),
                       1'($urandom()));
      end
      send_read(0);
      set_regs(1, 1, 1'b1, 1'b0);
      send_read(0);
      send_read(1);
   endtask

   task automatic test_random_traffic();
      int unsigned g;
      int unsigned v;
      int          n_sent;
      int          len;
      int unsigned pick;
      for (int phase = 0; phase < 10; phase++) begin
         g = $urandom_range(7);
         case ($urandom_range(9))
            0: v = 0;
            1: v = 1024;
            2: v = $urandom_range(1025, 2047);
            3: v = 1;
            default: v = $urandom_range(2, 48);
         endcase
         set_regs(g, v, 1'($urandom()), $urandom_range(3) == 0);
         // one phase runs back to back with no gaps
         idle_pct = (phase == 3) ? 0 : 23;
         if (clears_left > 0 && $urandom_range(3) == 0) begin
            send_op(OP_CLEAR);
            clears_left--;
         end
         n_sent = 0;
         while (n_sent < 65) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
               len = $urandom_range(1, 6);
               for (int e = 0; e < len; e++) begin
                  send_accum(rand_pos(), rand_pos(),
                             ($urandom_range(99) < 85) ? $urandom_range(vocab_eff() - 1)
                                                       : $urandom_range(1023),
                             rand_weight(), e == len - 1);
               end
               n_sent += len;
            end else if (pick < 88) begin
               send_read(pick_read_bin());
               n_sent++;
            end else if (pick < 95) begin
               // truncated feature: elements with no closing mark
               len = $urandom_range(1, 3);
               for (int e = 0; e < len; e++)
                  send_accum(rand_pos(), rand_pos(), $urandom_range(1023), rand_weight(), 1'b0);
               n_sent += len;
            end else begin
               send_op(OP_UNUSED);
            end
         end
      end
      idle_pct = 23;
   endtask

   always @(posedge clock) begin : check_rsp
      bin_reading_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reads.size() == 0) begin
            $error("unexpected response: bin_value %0h out_of_range %0b",
                   rsp_bin_value, rsp_out_of_range);
            n_errors++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_bin_value !== want.value) begin
               $error("bin_value: expected %0h, actual %0h", want.value, rsp_bin_value);
               n_errors++;
            end
            if (rsp_out_of_range !== want.oor) begin
               $error("out_of_range: expected %0b, actual %0b", want.oor, rsp_out_of_range);
               n_errors++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_full_grid();
      test_reg_bounds();
      test_saturation();
      test_random_traffic();
      req_start <= 1'b0;
      while (pending_reads.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (n_errors == 0)
         $display("tb_spatial_word_histogram_unit: done, clean");
      else
         $display("tb_spatial_word_histogram_unit: done, errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_spatial_word_histogram_unit: done, errors");
      $finish;
   end

endmodule
